>>> rtl/core/ppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

  // Field and datapath widths.
  localparam int GAIN_W      = 16;
  localparam int COUNT_W     = 10;
  localparam int MM_W        = 8;
  localparam int DUTY_W      = 8;
  localparam int EFF_W       = 9;
  localparam int ERR_W       = 21;
  localparam int STATE_W     = 32;
  localparam int DERR_W      = STATE_W + 1;
  localparam int MUL_A_W     = GAIN_W + 1;
  localparam int MUL_B_W     = STATE_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int SCALE_SH    = 8;
  localparam int SCALE_W     = PROD_W - SCALE_SH;
  localparam int QUO_W       = 18;
  localparam int DIV_CNT_W   = $clog2(QUO_W);
  localparam int STEP_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 2 * DUTY_W + EFF_W;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_P_RESET   = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_I_RESET   = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RESET   = 16'd0;
  localparam logic [COUNT_W-1:0] POT_LOW_RESET  = 10'd150;
  localparam logic [COUNT_W-1:0] POT_HIGH_RESET = 10'd1023;
  localparam logic [MM_W-1:0]    TRAVEL_RESET   = 8'd25;
  localparam logic [DUTY_W-1:0]  DUTY_RESET     = 8'd255;

  localparam logic [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_POT_LOW,
    REG_POT_HIGH,
    REG_TRAVEL,
    REG_DUTY_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MSEL_MAP,
    MSEL_P,
    MSEL_I,
    MSEL_D
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_IF_DEMO,
    JMP_DIV_LOOP,
    JMP_WAIT_OUT
  } jmp_t;

  // One microcode word.
  typedef struct packed {
    mul_sel_t          mul_sel;
    logic              mul_en;
    acc_op_t           acc_op;
    logic              div_load;
    logic              div_step;
    logic              err_calc;
    logic              state_upd;
    logic              scale;
    logic              emit;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Commands from the sequencer to the serial divider.
  typedef struct packed {
    logic load;
    logic step;
  } div_cmd_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_MAP  = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV_LOAD = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIV_STEP = 4'd3;
  localparam logic [STEP_W-1:0] ST_ERR      = 4'd4;
  localparam logic [STEP_W-1:0] ST_STATE    = 4'd5;
  localparam logic [STEP_W-1:0] ST_MUL_P    = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL_I    = 4'd7;
  localparam logic [STEP_W-1:0] ST_MUL_D    = 4'd8;
  localparam logic [STEP_W-1:0] ST_ACC      = 4'd9;
  localparam logic [STEP_W-1:0] ST_SCALE    = 4'd10;
  localparam logic [STEP_W-1:0] ST_EMIT     = 4'd11;

  // Control store.
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    w.mul_sel = MSEL_MAP;
    w.acc_op  = ACC_HOLD;
    w.jmp     = JMP_NEXT;
    w.target  = ST_IDLE;
    case (step)
      ST_IDLE: begin
        w.jmp = JMP_WAIT_IN;
      end
      ST_MUL_MAP: begin
        w.mul_sel = MSEL_MAP;
        w.mul_en  = 1'b1;
        w.jmp     = JMP_IF_DEMO;
        w.target  = ST_ERR;
      end
      ST_DIV_LOAD: begin
        w.div_load = 1'b1;
      end
      ST_DIV_STEP: begin
        w.div_step = 1'b1;
        w.jmp      = JMP_DIV_LOOP;
      end
      ST_ERR: begin
        w.err_calc = 1'b1;
      end
      ST_STATE: begin
        w.state_upd = 1'b1;
      end
      ST_MUL_P: begin
        w.mul_sel = MSEL_P;
        w.mul_en  = 1'b1;
      end
      ST_MUL_I: begin
        w.mul_sel = MSEL_I;
        w.mul_en  = 1'b1;
        w.acc_op  = ACC_LOAD;
      end
      ST_MUL_D: begin
        w.mul_sel = MSEL_D;
        w.mul_en  = 1'b1;
        w.acc_op  = ACC_ADD;
      end
      ST_ACC: begin
        w.acc_op = ACC_ADD;
      end
      ST_SCALE: begin
        w.scale = 1'b1;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_WAIT_OUT;
        w.target = ST_IDLE;
      end
      default: begin
        w.jmp    = JMP_WAIT_OUT;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ppd_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per step, unsigned operands.
module ppd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  ppd_pkg::div_cmd_t             cmd,
  input  logic [ppd_pkg::QUO_W-1:0]     dividend,
  input  logic [ppd_pkg::MM_W-1:0]      divisor,
  output logic [ppd_pkg::QUO_W-1:0]     quotient,
  output logic                          last
);
  import ppd_pkg::*;

  logic [QUO_W-1:0]     quo;
  logic [MM_W-1:0]      rem;
  logic [MM_W-1:0]      dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MM_W:0]        trial;
  logic [MM_W:0]        diff;
  logic                 fits;

  assign trial    = {rem, quo[QUO_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;
  assign last     = cnt == DIV_CNT_W'(QUO_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cmd.step) begin
      quo <= {quo[QUO_W-2:0], fits};
      rem <= fits ? diff[MM_W-1:0] : trial[MM_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pid_position_hbridge_drive.sv
`timescale 1ns / 1ps
`default_nettype none

// A request is taken only at the idle step, so the block works on one request
// at a time; the travel mapping runs through the 18-step serial divider,
// which demo mode skips. The next request is taken while a result waits.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears the previous error, the error sum, the step counter and m_tvalid.
module pid_position_hbridge_drive (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Request stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // target_mm[7:0], manual_setpoint[17:8], position_count[27:18],
  // limit_far[28], limit_near[29], zero fill[31:30]
  input  logic [ppd_pkg::IN_TDATA_W-1:0]      s_tdata,
  // demo_mode[0]
  input  logic                                s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // forward_duty[7:0], reverse_duty[15:8], effort_value[24:16],
  // zero fill[31:25]
  output logic [ppd_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import ppd_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [COUNT_W-1:0] pot_low;
  logic [COUNT_W-1:0] pot_high;
  logic [MM_W-1:0]    travel;
  logic [DUTY_W-1:0]  duty_limit;

  // Captured request fields.
  logic [MM_W-1:0]    tgt;
  logic [COUNT_W-1:0] manual;
  logic [COUNT_W-1:0] position;
  logic               lim_far;
  logic               lim_near;
  logic               demo;

  // Loop state carried from tick to tick, and its next values.
  logic [STATE_W-1:0] prev_err;
  logic [STATE_W-1:0] err_sum;
  logic [STATE_W-1:0] sum_sat;
  logic [STATE_W-1:0] sum_sat_prev;

  // Datapath registers.
  logic [ERR_W-1:0]          err;
  logic [DERR_W-1:0]         derr;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         acc;
  logic [SCALE_W-1:0]        scaled;
  logic                      map_neg;

  // Sequencer.
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  uword_t            ctrl;
  logic              in_acc;
  logic              out_free;
  logic              emit_now;

  // Divider hookup.
  div_cmd_t          div_cmd;
  logic [QUO_W-1:0]  div_quo;
  logic              div_last;
  logic [PROD_W-1:0] map_mag;
  logic [MM_W-1:0]   divisor;

  // The microcode word for the current step drives everything below.
  assign ctrl     = ucode_rom(pc);
  assign s_tready = ctrl.jmp == JMP_WAIT_IN;
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign emit_now = ctrl.emit && out_free;

  always_comb begin
    pc_next = pc;
    unique case (ctrl.jmp)
      JMP_NEXT:     pc_next = pc + 1'b1;
      JMP_WAIT_IN:  pc_next = in_acc ? pc + 1'b1 : pc;
      JMP_IF_DEMO:  pc_next = demo ? ctrl.target : pc + 1'b1;
      JMP_DIV_LOOP: pc_next = div_last ? pc + 1'b1 : pc;
      JMP_WAIT_OUT: pc_next = out_free ? ctrl.target : pc;
      default:      pc_next = ST_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= ST_IDLE;
      m_tvalid   <= 1'b0;
      prev_err   <= '0;
      err_sum    <= '0;
      gain_p     <= GAIN_P_RESET;
      gain_i     <= GAIN_I_RESET;
      gain_d     <= GAIN_D_RESET;
      pot_low    <= POT_LOW_RESET;
      pot_high   <= POT_HIGH_RESET;
      travel     <= TRAVEL_RESET;
      duty_limit <= DUTY_RESET;
    end else begin
      pc <= pc_next;
      if (emit_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctrl.state_upd) begin
        prev_err <= sum_sat_prev;
        err_sum  <= sum_sat;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GAIN_P:     gain_p     <= cfg_data;
          REG_GAIN_I:     gain_i     <= cfg_data;
          REG_GAIN_D:     gain_d     <= cfg_data;
          REG_POT_LOW:    pot_low    <= cfg_data[COUNT_W-1:0];
          REG_POT_HIGH:   pot_high   <= cfg_data[COUNT_W-1:0];
          REG_TRAVEL:     travel     <= cfg_data[MM_W-1:0];
          REG_DUTY_LIMIT: duty_limit <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Shared multiplier: one 17 x 33 signed product per step. The span between
  // the two calibration counts is a signed 11-bit value.
  logic signed [COUNT_W:0]  span;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  assign span = $signed({1'b0, pot_high}) - $signed({1'b0, pot_low});

  always_comb begin
    unique case (ctrl.mul_sel)
      MSEL_MAP: begin
        mul_a = $signed({{(MUL_A_W-MM_W){1'b0}}, tgt});
        mul_b = $signed({{(MUL_B_W-COUNT_W-1){span[COUNT_W]}}, span});
      end
      MSEL_P: begin
        mul_a = $signed({gain_p[GAIN_W-1], gain_p});
        mul_b = $signed({{(MUL_B_W-ERR_W){err[ERR_W-1]}}, err});
      end
      MSEL_I: begin
        mul_a = $signed({gain_i[GAIN_W-1], gain_i});
        mul_b = $signed({err_sum[STATE_W-1], err_sum});
      end
      MSEL_D: begin
        mul_a = $signed({gain_d[GAIN_W-1], gain_d});
        mul_b = $signed(derr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The mapping divides the magnitude of the product and restores the sign
  // afterwards, which gives truncation toward zero. A travel of zero counts
  // as one millimetre.
  assign map_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign divisor = (travel == '0) ? MM_W'(1) : travel;
  assign div_cmd = '{load: ctrl.div_load, step: ctrl.div_step};

  ppd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (map_mag[QUO_W-1:0]),
    .divisor  (divisor),
    .quotient (div_quo),
    .last     (div_last)
  );

  // Error: setpoint minus feedback, the setpoint being either the manual
  // count or the mapped target offset by the zero-travel count.
  logic [ERR_W-1:0] quo_ext;
  logic [ERR_W-1:0] quo_signed;
  logic [ERR_W-1:0] setpoint;
  logic [ERR_W-1:0] err_next;

  assign quo_ext    = {{(ERR_W-QUO_W){1'b0}}, div_quo};
  assign quo_signed = map_neg ? ERR_W'(-quo_ext) : quo_ext;
  assign setpoint   = demo ? {{(ERR_W-COUNT_W){1'b0}}, manual}
                           : quo_signed + {{(ERR_W-COUNT_W){1'b0}}, pot_low};
  assign err_next   = setpoint - {{(ERR_W-COUNT_W){1'b0}}, position};

  // Running sum with saturation at the 32-bit signed limits. An overflow
  // shows as the two top bits of the 33-bit sum disagreeing.
  logic [STATE_W:0]   err_wide;
  logic [STATE_W:0]   sum_wide;
  logic [DERR_W-1:0]  derr_next;

  assign err_wide     = {{(STATE_W+1-ERR_W){err[ERR_W-1]}}, err};
  assign sum_wide     = {err_sum[STATE_W-1], err_sum} + err_wide;
  assign sum_sat      = (sum_wide[STATE_W] != sum_wide[STATE_W-1])
                        ? (sum_wide[STATE_W] ? STATE_MIN : STATE_MAX)
                        : sum_wide[STATE_W-1:0];
  assign sum_sat_prev = err_wide[STATE_W-1:0];
  assign derr_next    = err_wide - {prev_err[STATE_W-1], prev_err};

  // Division by 256 truncated toward zero: bias negative sums before the
  // arithmetic shift.
  logic [PROD_W-1:0] acc_biased;

  assign acc_biased = acc + (acc[PROD_W-1] ? PROD_W'((1 << SCALE_SH) - 1) : '0);

  // Saturation to the duty limit and the H-bridge leg selection.
  logic [SCALE_W-1:0] lim_pos;
  logic [SCALE_W-1:0] lim_neg;
  logic [EFF_W-1:0]   effort;
  logic [EFF_W-1:0]   effort_mag;
  logic [DUTY_W-1:0]  fwd;
  logic [DUTY_W-1:0]  rev;

  assign lim_pos = {{(SCALE_W-DUTY_W){1'b0}}, duty_limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if ($signed(scaled) > $signed(lim_pos)) begin
      effort = lim_pos[EFF_W-1:0];
    end else if ($signed(scaled) < $signed(lim_neg)) begin
      effort = lim_neg[EFF_W-1:0];
    end else begin
      effort = scaled[EFF_W-1:0];
    end
  end

  assign effort_mag = -effort;

  // The far switch wins over the near one; both override the loop drive
  // but leave the reported effort alone.
  always_comb begin
    fwd = '0;
    rev = '0;
    priority if (lim_far) begin
      rev = duty_limit;
    end else if (lim_near) begin
      fwd = duty_limit;
    end else if (effort[EFF_W-1]) begin
      rev = effort_mag[DUTY_W-1:0];
    end else begin
      fwd = effort[DUTY_W-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt      <= s_tdata[7:0];
      manual   <= s_tdata[17:8];
      position <= s_tdata[27:18];
      lim_far  <= s_tdata[28];
      lim_near <= s_tdata[29];
      demo     <= s_tuser;
    end
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.div_load) begin
      map_neg <= prod[PROD_W-1];
    end
    if (ctrl.err_calc) begin
      err <= err_next;
    end
    if (ctrl.state_upd) begin
      derr <= derr_next;
    end
    unique case (ctrl.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase
    if (ctrl.scale) begin
      scaled <= acc_biased[PROD_W-1:SCALE_SH];
    end
    if (emit_now) begin
      m_tdata <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, effort, rev, fwd};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ppd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ppd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ppd_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import ppd_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The block does not take a request in the cycle after taking one.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken on consecutive cycles");

  // The two bridge legs are never driven together.
  a_one_leg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[7:0] != 8'd0 && m_tdata[15:8] != 8'd0))
    else $error("both bridge legs driven");

  // Fill bits above the effort stay zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("result fill bits not zero");

endmodule

bind pid_position_hbridge_drive ppd_checker u_ppd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/tb_pid_position_hbridge_drive.sv
`timescale 1ns / 1ps

module tb_pid_position_hbridge_drive;
  import ppd_pkg::*;

  // The run is stopped here whatever happens. The slowest correct run is
  // under two thousand ticks, stretched by stalls.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Tail wait after the last result.
  localparam int DRAIN_TAIL = 40;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  // One control tick as the block sees it.
  typedef struct {
    logic [7:0] target_mm;
    logic [9:0] manual_setpoint;
    logic [9:0] position_count;
    logic       demo_mode;
    logic       limit_far;
    logic       limit_near;
  } tick_t;

  // One drive result.
  typedef struct {
    logic [7:0]        forward_duty;
    logic [7:0]        reverse_duty;
    logic signed [8:0] effort_value;
  } drive_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  pid_position_hbridge_drive i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Our own copy of the register file, loaded with the reset values.
  logic signed [15:0] kp = 16'sd256;
  logic signed [15:0] ki = 16'sd0;
  logic signed [15:0] kd = 16'sd0;
  logic [9:0]         low_cnt = 10'd150;
  logic [9:0]         high_cnt = 10'd1023;
  logic [7:0]         travel_mm = 8'd25;
  logic [7:0]         duty_max = 8'd255;

  // Controller state as it should be after the last accepted request.
  int last_err = 0;
  int err_sum = 0;

  tick_t  tick_q[$];    // requests waiting for the driver
  drive_t drive_q[$];   // drive results still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned n_settings = 0;
  int unsigned n_override = 0;
  int unsigned n_clamped = 0;
  int unsigned n_sum_sat = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Setpoint in counts. A travel of zero is taken as one, and targets past
  // the travel are extrapolated, not clipped.
  function automatic longint setpoint_of(tick_t t);
    longint span_div;
    span_div = (travel_mm == 8'd0) ? 64'sd1 : longint'(travel_mm);
    if (t.demo_mode) return longint'(t.manual_setpoint);
    return longint'(t.target_mm) * (longint'(high_cnt) - longint'(low_cnt)) / span_div
           + longint'(low_cnt);
  endfunction

  // Advances the controller state by one tick and returns the drive it
  // should produce.
  function automatic drive_t predict_drive(tick_t t);
    longint err;
    longint derr;
    longint sum;
    longint acc;
    longint eff;
    longint lim;
    drive_t d;
    err  = setpoint_of(t) - longint'(t.position_count);
    derr = err - longint'(last_err);
    sum  = longint'(err_sum) + err;
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
      n_sum_sat++;
    end else if (sum < SUM_MIN) begin
      sum = SUM_MIN;
      n_sum_sat++;
    end
    err_sum  = int'(sum);
    last_err = int'(err);

    // Q8.8 gains: the division by 256 truncates toward zero, as SV does.
    acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * derr;
    eff = acc / 256;
    lim = longint'(duty_max);
    if (eff > lim) begin
      eff = lim;
      n_clamped++;
    end else if (eff < -lim) begin
      eff = -lim;
      n_clamped++;
    end

    d.effort_value = eff[8:0];
    d.forward_duty = (eff > 0) ? eff[7:0] : 8'd0;
    d.reverse_duty = (eff < 0) ? 8'(-eff) : 8'd0;

    // A pressed switch drives away from it; the far switch wins over the
    // near one. The effort field still shows the computed value.
    if (t.limit_far) begin
      d.forward_duty = 8'd0;
      d.reverse_duty = duty_max;
      n_override++;
    end else if (t.limit_near) begin
      d.forward_duty = duty_max;
      d.reverse_duty = 8'd0;
      n_override++;
    end
    return d;
  endfunction

  function automatic tick_t make_tick(logic [7:0] target, logic [9:0] manual,
                                      logic [9:0] pos, logic demo, logic far_sw,
                                      logic near_sw);
    tick_t t;
    t.target_mm       = target;
    t.manual_setpoint = manual;
    t.position_count  = pos;
    t.demo_mode       = demo;
    t.limit_far       = far_sw;
    t.limit_near      = near_sw;
    return t;
  endfunction

  // Random tick. Half of them put the position close to the setpoint so that
  // the effort often stays inside the duty limit instead of clamping.
  function automatic tick_t random_tick();
    tick_t  t;
    longint sp;
    if ($urandom_range(3) == 0) t.target_mm = 8'($urandom_range(255));
    else t.target_mm = 8'($urandom_range(travel_mm));
    t.manual_setpoint = 10'($urandom_range(1023));
    t.demo_mode       = ($urandom_range(9) < 3);
    t.limit_far       = ($urandom_range(9) == 0);
    t.limit_near      = ($urandom_range(9) == 0);
    if ($urandom_range(1) == 1) begin
      sp = setpoint_of(t) + longint'($urandom_range(40)) - 20;
      if (sp < 0) sp = 0;
      if (sp > 1023) sp = 1023;
      t.position_count = sp[9:0];
    end else begin
      t.position_count = 10'($urandom_range(1023));
    end
    return t;
  endfunction

  task automatic queue_tick(tick_t t);
    tick_q.push_back(t);
    n_queued++;
  endtask

  // One register write per cycle; the mirror follows at once, which is safe
  // because writes only happen while the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_GAIN_P:     kp = val;
      REG_GAIN_I:     ki = val;
      REG_GAIN_D:     kd = val;
      REG_POT_LOW:    low_cnt = val[9:0];
      REG_POT_HIGH:   high_cnt = val[9:0];
      REG_TRAVEL:     travel_mm = val[7:0];
      REG_DUTY_LIMIT: duty_max = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                           logic [9:0] lo, logic [9:0] hi, logic [7:0] trav,
                           logic [7:0] duty);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_POT_LOW, {6'd0, lo});
    write_reg(REG_POT_HIGH, {6'd0, hi});
    write_reg(REG_TRAVEL, {8'd0, trav});
    write_reg(REG_DUTY_LIMIT, {8'd0, duty});
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Waits until every queued request has been taken and answered, then lets
  // the pipeline settle. Polling on the falling edge keeps clear of the
  // driver and monitor, which update their counters on the rising edge.
  task automatic wait_drain();
    do @(negedge clk); while (n_accepted != n_queued || drive_q.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Request driver. A new request is presented only when the slot is free,
  // so tvalid gets one assignment per edge and never drops while waiting.
  always @(posedge clk) begin
    tick_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        t.target_mm       = s_tdata[7:0];
        t.manual_setpoint = s_tdata[17:8];
        t.position_count  = s_tdata[27:18];
        t.limit_far       = s_tdata[28];
        t.limit_near      = s_tdata[29];
        t.demo_mode       = s_tuser;
        drive_q.push_back(predict_drive(t));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          t = tick_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, t.limit_near, t.limit_far, t.position_count,
                       t.manual_setpoint, t.target_mm};
          s_tuser  <= t.demo_mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every accepted result is held against the oldest
  // expected drive, field by field.
  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result, tdata %h", m_tdata);
          n_fail++;
        end else begin
          want = drive_q.pop_front();
          n_checked++;
          if (m_tdata[7:0] !== want.forward_duty) begin
            $error("forward_duty: expected %0d, actual %0d", want.forward_duty,
                   m_tdata[7:0]);
            n_fail++;
          end
          if (m_tdata[15:8] !== want.reverse_duty) begin
            $error("reverse_duty: expected %0d, actual %0d", want.reverse_duty,
                   m_tdata[15:8]);
            n_fail++;
          end
          if (m_tdata[24:16] !== want.effort_value) begin
            $error("effort_value: expected %0d, actual %0d", want.effort_value,
                   $signed(m_tdata[24:16]));
            n_fail++;
          end
          if (m_tdata[31:25] !== 7'd0) begin
            $error("zero fill: expected 0, actual %h", m_tdata[31:25]);
            n_fail++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles with %0d results outstanding",
             cycle_count, drive_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // First third: the sender pauses a little, the receiver a lot.
    send_idle_pct = 28;
    recv_idle_pct = 74;

    // Directed ticks on the reset register values (unity P gain, 150..1023
    // counts over 25 mm, full duty).
    queue_tick(make_tick(8'd0, 10'd0, 10'd150, 1'b0, 1'b0, 1'b0));     // zero effort
    queue_tick(make_tick(8'd25, 10'd0, 10'd1023, 1'b0, 1'b0, 1'b0));   // full travel
    queue_tick(make_tick(8'd12, 10'd0, 10'd560, 1'b0, 1'b0, 1'b0));    // small error
    queue_tick(make_tick(8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));     // past travel
    queue_tick(make_tick(8'd0, 10'd0, 10'd1023, 1'b0, 1'b0, 1'b0));    // negative clamp
    queue_tick(make_tick(8'd0, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b0));    // demo, max
    queue_tick(make_tick(8'd0, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b0));    // demo, min
    queue_tick(make_tick(8'd0, 10'd600, 10'd590, 1'b1, 1'b0, 1'b0));   // demo, +10
    queue_tick(make_tick(8'd0, 10'd590, 10'd600, 1'b1, 1'b0, 1'b0));   // demo, -10
    queue_tick(make_tick(8'd0, 10'd512, 10'd512, 1'b1, 1'b0, 1'b0));   // demo, zero
    queue_tick(make_tick(8'd20, 10'd0, 10'd100, 1'b0, 1'b1, 1'b0));    // far switch
    queue_tick(make_tick(8'd0, 10'd0, 10'd900, 1'b0, 1'b0, 1'b1));     // near switch
    queue_tick(make_tick(8'd10, 10'd0, 10'd300, 1'b0, 1'b1, 1'b1));    // both switches
    queue_tick(make_tick(8'd0, 10'd0, 10'd150, 1'b0, 1'b0, 1'b1));     // near, no effort
    queue_tick(make_tick(8'd255, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b1)); // all ones
    queue_tick(make_tick(8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));       // all zeros
    wait_drain();

    // Derivative and integral terms with small gains before the sweep.
    load_regs(16'd256, 16'd16, 16'd128, 10'd150, 10'd1023, 8'd25, 8'd255);
    queue_tick(make_tick(8'd10, 10'd0, 10'd400, 1'b0, 1'b0, 1'b0));
    queue_tick(make_tick(8'd10, 10'd0, 10'd500, 1'b0, 1'b0, 1'b0));
    queue_tick(make_tick(8'd10, 10'd0, 10'd499, 1'b0, 1'b0, 1'b0));
    queue_tick(make_tick(8'd5, 10'd0, 10'd400, 1'b0, 1'b0, 1'b0));
    wait_drain();

    // Random sweep over nine register settings, three per idling profile.
    for (k = 0; k < 9; k++) begin
      if (k == 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 28;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k)
        // Reset values again.
        0: load_regs(16'd256, 16'd0, 16'd0, 10'd150, 10'd1023, 8'd25, 8'd255);
        // Extreme gains, widest span, longest travel.
        1: load_regs(16'h7FFF, 16'd0, 16'h8000, 10'd0, 10'd1023, 8'd255, 8'd255);
        // Falling span over the shortest travel and the smallest duty.
        2: load_regs(16'd300, 16'd2, 16'd100, 10'd1023, 10'd0, 8'd1, 8'd1);
        // Zero travel and zero duty limit.
        3: load_regs(16'd512, 16'hFFFF, 16'd64, 10'd200, 10'd800, 8'd0, 8'd0);
        // Opposite extreme gains on an empty span.
        4: load_regs(16'h8000, 16'h7FFF, 16'h7FFF, 10'd512, 10'd512, 8'd200, 8'd128);
        // Moderate gains of either sign.
        5, 8: load_regs(16'($urandom_range(2047)) - 16'd1024,
                        16'($urandom_range(63)) - 16'd32,
                        16'($urandom_range(1023)) - 16'd512,
                        10'($urandom_range(1023)), 10'($urandom_range(1023)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
        // Everything at random across its full range.
        6: load_regs(16'($urandom), 16'($urandom), 16'($urandom),
                     10'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
        default: load_regs(16'd600, 16'd3, 16'd200, 10'd150, 10'd1023, 8'd25,
                           8'd255);
      endcase
      repeat (185) queue_tick(random_tick());
      wait_drain();
    end

    // Integral wind-up: the largest possible error each tick grows the error
    // sum quickly, then negative ticks pull it back down a little.
    load_regs(16'd0, 16'd1, 16'd0, 10'd0, 10'd1023, 8'd1, 8'd255);
    repeat (60)
      queue_tick(make_tick(8'd255, 10'($urandom_range(1023)), 10'd0, 1'b0,
                           ($urandom_range(15) == 0), ($urandom_range(15) == 0)));
    repeat (25)
      queue_tick(make_tick(8'd0, 10'($urandom_range(1023)), 10'd1023, 1'b0,
                           1'b0, 1'b0));
    wait_drain();

    $display("Checked %0d drive results from %0d ticks over %0d register settings.",
             n_checked, n_accepted, n_settings);
    $display("Effort clamped %0d times, switch override %0d times, error sum held %0d times.",
             n_clamped, n_override, n_sum_sat);
    if (n_fail == 0 && drive_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ppd_pkg.sv
rtl/core/ppd_div.sv
rtl/core/pid_position_hbridge_drive.sv
rtl/core/ppd_checker.sv
test/tb_pid_position_hbridge_drive.sv
